FILE: rtl/wsalu_pkg.sv
// Shared types and codes for the width-selectable integer ALU.
package wsalu_pkg;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned HALF_W = DATA_W / 2;

    typedef enum logic [3:0] {
        ACT_ADD  = 4'd0,
        ACT_SUB  = 4'd1,
        ACT_MUL  = 4'd2,
        ACT_DIV  = 4'd3,
        ACT_MOD  = 4'd4,
        ACT_SHL  = 4'd5,
        ACT_SHR  = 4'd6,
        ACT_NOTA = 4'd7,
        ACT_NOTB = 4'd8,
        ACT_AND  = 4'd9,
        ACT_OR   = 4'd10,
        ACT_XOR  = 4'd11
    } t_action;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DIV0  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [3:0]        action;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic [1:0]        status;
    } t_rsp;

    // Request state as it travels down the chain
    typedef struct packed {
        logic [3:0]        action;
        logic              skip_check;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] res;
        logic [DATA_W-1:0] aux;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] quo;
    } t_stage;

endpackage

FILE: rtl/wsalu_front.sv
// Entry stage: simple operations and multiplier partial products.
module wsalu_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  wsalu_pkg::t_req   i_req,
    output logic              o_ready,
    output logic              o_valid,
    output wsalu_pkg::t_stage o_data,
    input  logic              i_ready
);
    import wsalu_pkg::*;

    logic   r_valid;
    t_stage r_data;
    t_stage n_data;
    logic [DATA_W-1:0] a_lo_b_lo;
    logic [DATA_W-1:0] a_lo_b_hi;
    logic [DATA_W-1:0] a_hi_b_lo;
    logic              shift_ok;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Form partial products and the results of the simple operations
    always_comb begin
        a_lo_b_lo = i_req.operand_a[HALF_W-1:0] * i_req.operand_b[HALF_W-1:0];
        a_lo_b_hi = i_req.operand_a[HALF_W-1:0] * i_req.operand_b[DATA_W-1:HALF_W];
        a_hi_b_lo = i_req.operand_a[DATA_W-1:HALF_W] * i_req.operand_b[HALF_W-1:0];
        shift_ok  = (i_req.operand_b[DATA_W-1:6] == '0);
        n_data            = '0;
        n_data.action     = i_req.action;
        n_data.a          = i_req.operand_a;
        n_data.b          = i_req.operand_b;
        n_data.aux        = {a_lo_b_hi[HALF_W-1:0], a_hi_b_lo[HALF_W-1:0]};
        case (i_req.action)
            ACT_ADD:  n_data.res = i_req.operand_a + i_req.operand_b;
            ACT_SUB:  n_data.res = i_req.operand_a - i_req.operand_b;
            ACT_MUL:  n_data.res = a_lo_b_lo;
            ACT_DIV, ACT_MOD: n_data.res = '0;
            ACT_SHL: begin
                n_data.res        = shift_ok ? (i_req.operand_a << i_req.operand_b[5:0]) : '0;
                n_data.skip_check = !shift_ok;
            end
            ACT_SHR: begin
                n_data.res        = shift_ok ? (i_req.operand_a >> i_req.operand_b[5:0]) : '0;
                n_data.skip_check = !shift_ok;
            end
            ACT_NOTA: n_data.res = ~i_req.operand_a;
            ACT_NOTB: n_data.res = ~i_req.operand_b;
            ACT_AND:  n_data.res = i_req.operand_a & i_req.operand_b;
            ACT_OR:   n_data.res = i_req.operand_a | i_req.operand_b;
            ACT_XOR:  n_data.res = i_req.operand_a ^ i_req.operand_b;
            default: begin
                n_data.res        = '0;
                n_data.skip_check = 1'b1;
            end
        endcase
    end

    // Hold or advance the stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

FILE: rtl/wsalu_div_cell.sv
// One restoring division cell: settles one quotient bit per request.
module wsalu_div_cell #(
    parameter int unsigned BIT_IDX = 63
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  wsalu_pkg::t_stage i_data,
    output logic              o_ready,
    output logic              o_valid,
    output wsalu_pkg::t_stage o_data,
    input  logic              i_ready
);
    import wsalu_pkg::*;

    logic   r_valid;
    t_stage r_data;
    t_stage n_data;
    logic [DATA_W:0] rem_sh;
    logic [DATA_W:0] rem_sub;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Shift in the next dividend bit and subtract where it fits
    always_comb begin
        n_data  = i_data;
        rem_sh  = {i_data.rem, i_data.a[BIT_IDX]};
        rem_sub = rem_sh - {1'b0, i_data.b};
        if (rem_sh >= {1'b0, i_data.b}) begin
            n_data.rem          = rem_sub[DATA_W-1:0];
            n_data.quo[BIT_IDX] = 1'b1;
        end else begin
            n_data.rem = rem_sh[DATA_W-1:0];
        end
    end

    // Hold or advance the cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

FILE: rtl/width_selectable_integer_alu.sv
// Top level: entry stage, chain of division cells and output register.
//
//  channel   valid     stall     payload   direction
//  request   i_valid   o_stall   i_req     in
//  response  o_valid   i_stall   o_rsp     out
//  config    i_cfg_we  -         i_cfg_data in
//
// One request per cycle while no stage is held; every request walks the entry stage,
// the chain of DATA_W one-bit division cells and the output register.
// Synchronous active-low reset empties the chain; width mode resets to 64.
// Each stage holds while its successor is full and stalled, so bubbles fill.
module width_selectable_integer_alu #(
    parameter int unsigned MAX_WIDTH = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  wsalu_pkg::t_req i_req,
    output logic            o_stall,
    output logic            o_valid,
    output wsalu_pkg::t_rsp o_rsp,
    input  logic            i_stall,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_data
);
    import wsalu_pkg::*;

    localparam int unsigned CELLS = DATA_W;

    logic [1:0] r_width_mode;
    logic       r_out_valid;
    t_rsp       r_rsp;
    t_rsp       n_rsp;

    logic   front_ready;
    logic   cell_valid [CELLS+1];
    t_stage cell_data  [CELLS+1];
    logic   cell_ready [CELLS+1];
    logic   out_ready;

    logic [7:0]        width_bits;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] mul_cross;
    logic [DATA_W-1:0] value;
    logic              skip;
    t_stage            last;

    assign o_stall = !front_ready;
    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

    wsalu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_req   (i_req),
        .o_ready (front_ready),
        .o_valid (cell_valid[0]),
        .o_data  (cell_data[0]),
        .i_ready (cell_ready[0])
    );

    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        wsalu_div_cell #(
            .BIT_IDX (CELLS - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cell_valid[k]),
            .i_data  (cell_data[k]),
            .o_ready (cell_ready[k]),
            .o_valid (cell_valid[k+1]),
            .o_data  (cell_data[k+1]),
            .i_ready (cell_ready[k+1])
        );
    end

    assign out_ready         = !r_out_valid || !i_stall;
    assign cell_ready[CELLS] = out_ready;
    assign last              = cell_data[CELLS];

    // Pick the final result and check it against the width
    always_comb begin
        width_bits = 8'd8 << r_width_mode;
        if (width_bits > 8'(MAX_WIDTH)) begin
            width_bits = 8'(MAX_WIDTH);
        end
        if (width_bits >= 8'(DATA_W)) begin
            mask = '1;
        end else begin
            mask = (64'd1 << width_bits[5:0]) - 64'd1;
        end
        mul_cross = {last.aux[DATA_W-1:HALF_W] + last.aux[HALF_W-1:0], {HALF_W{1'b0}}};
        skip      = last.skip_check;
        n_rsp.status = ST_OK;
        case (last.action)
            ACT_MUL:  value = last.res + mul_cross;
            ACT_DIV:  value = last.quo;
            ACT_MOD:  value = last.rem;
            ACT_NOTA, ACT_NOTB: value = last.res & mask;
            default:  value = last.res;
        endcase
        if ((last.action == ACT_DIV || last.action == ACT_MOD) && last.b == '0) begin
            value        = '0;
            skip         = 1'b1;
            n_rsp.status = ST_DIV0;
        end
        if (!skip && (value & ~mask) != '0) begin
            n_rsp.status = ST_RANGE;
        end
        n_rsp.result = value;
    end

    // Hold the response and the width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_width_mode <= 2'd3;
        end else begin
            if (out_ready) begin
                r_out_valid <= cell_valid[CELLS];
            end
            if (i_cfg_we) begin
                r_width_mode <= i_cfg_data;
            end
        end
        if (out_ready && cell_valid[CELLS]) begin
            r_rsp <= n_rsp;
        end
    end

endmodule

FILE: bench/tb_top.sv
// Testbench for the width-selectable integer ALU: random requests, predicted responses.
`timescale 1ns / 1ps
module tb_top;
    import wsalu_pkg::*;

    localparam int LATENCY    = DATA_W + 2;
    localparam int IDLE_LIMIT = 20000;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   req_valid = 1'b0;
    t_req   req_data = '0;
    logic   req_stall;
    logic   rsp_valid;
    t_rsp   rsp_data;
    logic   rsp_stall = 1'b0;
    logic   cfg_we = 1'b0;
    logic [1:0] cfg_data = 2'd0;

    logic [1:0] width_sel = 2'd3;
    t_req   pending_reqs[$];
    t_rsp   expected_rsps[$];
    int     mismatches = 0;
    int     idle_cycles = 0;
    bit     hold_rsp = 1'b0;
    int     hold_count = 0;
    int     send_gap = 0;
    int     recv_gap = 0;

    width_selectable_integer_alu i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (req_valid),
        .i_req     (req_data),
        .o_stall   (req_stall),
        .o_valid   (rsp_valid),
        .o_rsp     (rsp_data),
        .i_stall   (rsp_stall),
        .i_cfg_we  (cfg_we),
        .i_cfg_data(cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Compute the response the ALU should give for one request
    function automatic t_rsp alu_predict(t_req rq, logic [1:0] wsel);
        logic [63:0] mask;
        logic [63:0] a;
        logic [63:0] b;
        t_rsp        rs;
        bit          check;
        a = rq.operand_a;
        b = rq.operand_b;
        mask = (wsel == 2'd3) ? '1 : ((64'd1 << (8 << wsel)) - 64'd1);
        rs.result = '0;
        rs.status = ST_OK;
        check = 1'b1;
        case (rq.action)
            ACT_ADD:  rs.result = a + b;
            ACT_SUB:  rs.result = a - b;
            ACT_MUL:  rs.result = a * b;
            ACT_DIV, ACT_MOD: begin
                if (b != 0) begin
                    rs.result = (rq.action == ACT_DIV) ? a / b : a % b;
                end else begin
                    rs.status = ST_DIV0;
                    check = 1'b0;
                end
            end
            ACT_SHL, ACT_SHR: begin
                if (b < 64) begin
                    rs.result = (rq.action == ACT_SHL) ? a << b[5:0] : a >> b[5:0];
                end else begin
                    check = 1'b0;
                end
            end
            ACT_NOTA: rs.result = ~a & mask;
            ACT_NOTB: rs.result = ~b & mask;
            ACT_AND:  rs.result = a & b;
            ACT_OR:   rs.result = a | b;
            ACT_XOR:  rs.result = a ^ b;
            default:  check = 1'b0;
        endcase
        if (check && (rs.result & ~mask) != 0) begin
            rs.status = ST_RANGE;
        end
        return rs;
    endfunction

    function automatic logic [63:0] rand_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: v = v & 64'hff;
            1: v = v & 64'hffff;
            2: v = v & 64'hffff_ffff;
            3: v = 64'($urandom_range(0, 70));
            4: v = $urandom_range(0, 1) ? '1 : '0;
            default: ;
        endcase
        return v;
    endfunction

    function automatic t_req make_req(logic [3:0] act, logic [63:0] a, logic [63:0] b);
        t_req rq;
        rq.action = act;
        rq.operand_a = a;
        rq.operand_b = b;
        return rq;
    endfunction

    // Let the queue drain and the chain empty before touching the width
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_valid) begin
            @(posedge i_clk);
        end
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic set_width(logic [1:0] wsel);
        wait_idle();
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_data <= wsel;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        width_sel = wsel;
    endtask

    // Drive requests; hold the payload while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_valid <= 1'b0;
        end else if (req_valid && req_stall) begin
            // hold
        end else begin
            if (req_valid) begin
                expected_rsps.push_back(alu_predict(req_data, width_sel));
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                req_data <= pending_reqs.pop_front();
                req_valid <= 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    send_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                             : $urandom_range(1, 3);
                end
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random short and long gaps, or a forced long hold-off
    always @(posedge i_clk) begin
        if (hold_rsp) begin
            rsp_stall <= 1'b1;
            hold_count <= hold_count + 1;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_stall <= 1'b1;
        end else if ($urandom_range(0, 4) == 0) begin
            recv_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 80)
                                                     : $urandom_range(0, 3);
            rsp_stall <= 1'b1;
        end else begin
            rsp_stall <= 1'b0;
        end
    end

    // Check each accepted response against the oldest prediction
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n && rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected response result=%h status=%0d",
                             rsp_data.result, rsp_data.status);
                end
            end else begin
                exp_rsp = expected_rsps.pop_front();
                if (exp_rsp.result !== rsp_data.result || exp_rsp.status !== rsp_data.status) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected result=%h status=%0d, got result=%h status=%0d",
                                 exp_rsp.result, exp_rsp.status,
                                 rsp_data.result, rsp_data.status);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [63:0] ones;
        ones = '1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every operation, extremes, divide by zero, large shifts, unused codes
        for (int act = 0; act < 12; act++) begin
            pending_reqs.push_back(make_req(4'(act), ones, ones));
        end
        pending_reqs.push_back(make_req(ACT_DIV, 64'd5, 64'd0));
        pending_reqs.push_back(make_req(ACT_MOD, ones, 64'd0));
        pending_reqs.push_back(make_req(ACT_SHL, 64'd1, 64'd63));
        pending_reqs.push_back(make_req(ACT_SHL, 64'd1, 64'd64));
        pending_reqs.push_back(make_req(ACT_SHR, ones, ones));
        pending_reqs.push_back(make_req(ACT_ADD, ones, 64'd1));
        pending_reqs.push_back(make_req(ACT_SUB, 64'd0, 64'd1));
        pending_reqs.push_back(make_req(ACT_NOTA, 64'd0, 64'd0));
        pending_reqs.push_back(make_req(4'd12, 64'd3, 64'd4));
        pending_reqs.push_back(make_req(4'd15, ones, ones));
        wait_idle();

        // Random phases over several widths, extremes included
        for (int phase = 0; phase < 8; phase++) begin
            set_width(phase == 0 ? 2'd0 : phase == 1 ? 2'd3 : 2'($urandom_range(0, 3)));
            if (phase == 2) begin
                hold_rsp = 1'b1;
            end
            for (int n = 0; n < 200; n++) begin
                pending_reqs.push_back(make_req(($urandom_range(0, 15) == 0)
                                                ? 4'($urandom_range(12, 15))
                                                : 4'($urandom_range(0, 11)),
                                                rand_operand(), rand_operand()));
            end
            if (phase == 2) begin
                wait (hold_count >= 300);
                hold_rsp = 1'b0;
            end
        end

        wait_idle();
        if (mismatches == 0 && expected_rsps.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
